@@ design/hc2_pkg.sv @@
// ----------------------------------------------------------------------------
// hc2_pkg
// Shared types and constants for the 2x2 byte Hill cipher.
// ----------------------------------------------------------------------------
package hc2_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_A        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_B        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_C        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_D        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 3'd4;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_TWO  = 8'h02;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              message_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              pair_second;
    logic              out_end;
    logic              key_invalid;
  } out_item_t;

endpackage

@@ design/hill_cipher_2x2_mod256_top.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod256_top
// Pairs message bytes and multiplies each pair by a 2x2 key (or its inverse)
// modulo 256, one output byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
// A byte that completes a pair loads the pair register; the pair then moves
// into the result register, which offers its first and then second byte.
// Throughput: one input byte per cycle while the output does not stall and no
// key derivation runs; a one-byte message is padded to two output bytes.
// Every configuration write starts a key derivation (determinant, three Newton
// steps for the inverse, decrypt-mode adjugate scaling) that stalls the input.
// Reset (synchronous): identity key, encrypt mode, no byte held, both empty.
module hill_cipher_2x2_mod256_top
  import hc2_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input byte channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  localparam logic [3:0] STEP_IDLE = 4'd0;
  localparam logic [3:0] STEP_DET  = 4'd1;
  localparam logic [3:0] STEP_LAST = 4'd8;

  // configuration
  logic [BYTE_W-1:0] key_a, key_b, key_c, key_d;
  logic              decrypt_mode;

  // key derivation
  logic [3:0]        der_step;
  logic [BYTE_W-1:0] det;
  logic [BYTE_W-1:0] inv;
  logic [BYTE_W-1:0] newton_t;
  logic [BYTE_W-1:0] k00, k01, k10, k11;
  logic              key_bad;

  // pairing and pair register
  logic [BYTE_W-1:0] held_byte;
  logic              holding;
  logic              p_valid;
  logic [BYTE_W-1:0] p_x1, p_x2;
  logic              p_end;

  // result register
  logic              o_valid;
  logic              o_second;
  logic [BYTE_W-1:0] o_y1, o_y2;
  logic              o_end;
  logic              o_inv;

  logic              cfg_write;
  logic              busy;
  logic              in_accept;
  logic              out_accept;
  logic              o_done;
  logic              p_adv;
  logic              p_load;

  logic [2*BYTE_W-1:0] prod_ad, prod_bc, prod_det_inv, prod_inv_t;
  logic [2*BYTE_W-1:0] prod_dk, prod_bk, prod_ck, prod_ak;
  logic [2*BYTE_W-1:0] prod00, prod01, prod10, prod11;
  logic [BYTE_W-1:0]   inv_use;
  logic [BYTE_W-1:0]   y1, y2;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid & cfg_ready;
  assign busy       = (der_step != STEP_IDLE);
  assign out_accept = o_valid & ~out_stall;
  assign o_done     = out_accept & o_second;
  assign p_adv      = p_valid & (~o_valid | o_done);
  assign in_stall   = busy | (p_valid & ~(~o_valid | o_done));
  assign in_accept  = in_valid & ~in_stall;
  assign p_load     = in_accept & (holding | in_data.message_end);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      key_a        <= BYTE_ONE;
      key_b        <= BYTE_ZERO;
      key_c        <= BYTE_ZERO;
      key_d        <= BYTE_ONE;
      decrypt_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_A:        key_a        <= cfg_data;
        REG_KEY_B:        key_b        <= cfg_data;
        REG_KEY_C:        key_c        <= cfg_data;
        REG_KEY_D:        key_d        <= cfg_data;
        REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Key derivation: det, Newton inverse (x <- x*(2 - det*x)), adjugate scale
  // --------------------------------------------------------------------------
  assign prod_ad      = 16'(key_a) * 16'(key_d);
  assign prod_bc      = 16'(key_b) * 16'(key_c);
  assign prod_det_inv = 16'(det) * 16'(inv);
  assign prod_inv_t   = 16'(inv) * 16'(newton_t);

  // even determinant has no inverse: scale by zero
  assign inv_use = det[0] ? inv : BYTE_ZERO;
  assign prod_dk = 16'(key_d) * 16'(inv_use);
  assign prod_bk = 16'(BYTE_ZERO - key_b) * 16'(inv_use);
  assign prod_ck = 16'(BYTE_ZERO - key_c) * 16'(inv_use);
  assign prod_ak = 16'(key_a) * 16'(inv_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      der_step <= STEP_IDLE;
      k00      <= BYTE_ONE;
      k01      <= BYTE_ZERO;
      k10      <= BYTE_ZERO;
      k11      <= BYTE_ONE;
      key_bad  <= 1'b0;
    end else if (cfg_write) begin
      der_step <= STEP_DET;
    end else if (busy) begin
      if (der_step == STEP_LAST) begin
        der_step <= STEP_IDLE;
        if (decrypt_mode) begin
          k00     <= prod_dk[BYTE_W-1:0];
          k01     <= prod_bk[BYTE_W-1:0];
          k10     <= prod_ck[BYTE_W-1:0];
          k11     <= prod_ak[BYTE_W-1:0];
          key_bad <= ~det[0];
        end else begin
          k00     <= key_a;
          k01     <= key_b;
          k10     <= key_c;
          k11     <= key_d;
          key_bad <= 1'b0;
        end
      end else begin
        der_step <= der_step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (der_step == STEP_DET) begin
      det <= prod_ad[BYTE_W-1:0] - prod_bc[BYTE_W-1:0];
      inv <= prod_ad[BYTE_W-1:0] - prod_bc[BYTE_W-1:0];
    end else if (busy && der_step != STEP_LAST) begin
      // even steps form the correction term, odd steps apply it
      if (!der_step[0]) begin
        newton_t <= BYTE_TWO - prod_det_inv[BYTE_W-1:0];
      end else begin
        inv <= prod_inv_t[BYTE_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pairing: hold the first byte, pad a lone final byte with zero
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      holding   <= 1'b0;
      held_byte <= BYTE_ZERO;
    end else if (in_accept) begin
      if (!holding && !in_data.message_end) begin
        holding   <= 1'b1;
        held_byte <= in_data.data_byte;
      end else begin
        holding <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_load) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_x1  <= holding ? held_byte : in_data.data_byte;
      p_x2  <= holding ? in_data.data_byte : BYTE_ZERO;
      p_end <= in_data.message_end;
    end
  end

  // --------------------------------------------------------------------------
  // Matrix product and result register
  // --------------------------------------------------------------------------
  assign prod00 = 16'(k00) * 16'(p_x1);
  assign prod01 = 16'(k01) * 16'(p_x2);
  assign prod10 = 16'(k10) * 16'(p_x1);
  assign prod11 = 16'(k11) * 16'(p_x2);
  assign y1     = prod00[BYTE_W-1:0] + prod01[BYTE_W-1:0];
  assign y2     = prod10[BYTE_W-1:0] + prod11[BYTE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      o_second <= 1'b0;
    end else if (p_adv) begin
      o_valid  <= 1'b1;
      o_second <= 1'b0;
    end else if (out_accept) begin
      // advance to the second byte, drop after its transfer
      if (!o_second) begin
        o_second <= 1'b1;
      end else begin
        o_valid  <= 1'b0;
        o_second <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      o_y1  <= y1;
      o_y2  <= y2;
      o_end <= p_end;
      o_inv <= key_bad;
    end
  end

  assign out_valid            = o_valid;
  assign out_data.out_byte    = o_second ? o_y2 : o_y1;
  assign out_data.pair_second = o_second;
  assign out_data.out_end     = o_second & o_end;
  assign out_data.key_invalid = o_inv;

endmodule
